// ===== src/bsaw_pkg.sv =====
`default_nettype none

package bsaw_pkg;

    // default coordinate width of the rectangles
    localparam int COORD_BITS_DEF = 12;

    // result coordinates are always reported on this many bits
    localparam int OUT_BITS = 13;

    // configuration register index width
    localparam int REG_IDX_BITS = 3;

    // configuration register map
    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_SRC_LEFT,
        REG_SRC_TOP,
        REG_SRC_WIDTH,
        REG_SRC_HEIGHT,
        REG_DST_LEFT,
        REG_DST_TOP,
        REG_DST_WIDTH,
        REG_DST_HEIGHT
    } cfg_reg_t;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } walk_state_t;

    // sequencer to walk unit
    typedef struct packed {
        logic load;   // restart: preload the walk position
        logic step;   // run one iteration of the walk
    } walk_ctrl_t;

    // walk unit to sequencer
    typedef struct packed {
        logic active; // a walk is running
        logic emit;   // this iteration ends the request
        logic copy;   // the request ends with a pixel copy
        logic done;   // the request ends with the walk finished
    } walk_stat_t;

endpackage

`default_nettype wire

// ===== src/bsaw_geom.sv =====
`default_nettype none

module bsaw_geom #(
    parameter int COORD_BITS = bsaw_pkg::COORD_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [bsaw_pkg::REG_IDX_BITS-1:0] cfg_addr,
    input  wire logic [COORD_BITS:0]               cfg_wr_data,
    output logic      [COORD_BITS-1:0]             src_left,
    output logic      [COORD_BITS-1:0]             src_top,
    output logic      [COORD_BITS-1:0]             dst_left,
    output logic      [COORD_BITS-1:0]             dst_top,
    output logic      [COORD_BITS:0]               src_width,
    output logic      [COORD_BITS:0]               src_height,
    output logic      [COORD_BITS:0]               dst_width,
    output logic      [COORD_BITS:0]               dst_height,
    output logic      [COORD_BITS:0]               src_col_end,
    output logic      [COORD_BITS:0]               src_row_end,
    output logic      [COORD_BITS:0]               dst_col_end,
    output logic      [COORD_BITS:0]               dst_row_end,
    output logic                                   ident
);
    import bsaw_pkg::*;

    localparam int CW = COORD_BITS + 1;

    localparam logic [CW-1:0] SIZE_MAX = CW'(1) << COORD_BITS;

    logic [COORD_BITS-1:0] src_left_reg;
    logic [COORD_BITS-1:0] src_top_reg;
    logic [COORD_BITS-1:0] dst_left_reg;
    logic [COORD_BITS-1:0] dst_top_reg;
    logic [CW-1:0]         src_width_reg;
    logic [CW-1:0]         src_height_reg;
    logic [CW-1:0]         dst_width_reg;
    logic [CW-1:0]         dst_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_left_reg   <= '0;
            src_top_reg    <= '0;
            dst_left_reg   <= '0;
            dst_top_reg    <= '0;
            src_width_reg  <= '0;
            src_height_reg <= '0;
            dst_width_reg  <= '0;
            dst_height_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SRC_LEFT:   src_left_reg   <= cfg_wr_data[COORD_BITS-1:0];
                REG_SRC_TOP:    src_top_reg    <= cfg_wr_data[COORD_BITS-1:0];
                REG_SRC_WIDTH:  src_width_reg  <= cfg_wr_data;
                REG_SRC_HEIGHT: src_height_reg <= cfg_wr_data;
                REG_DST_LEFT:   dst_left_reg   <= cfg_wr_data[COORD_BITS-1:0];
                REG_DST_TOP:    dst_top_reg    <= cfg_wr_data[COORD_BITS-1:0];
                REG_DST_WIDTH:  dst_width_reg  <= cfg_wr_data;
                REG_DST_HEIGHT: dst_height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // sizes above the coordinate range saturate at its top
    assign src_width  = src_width_reg[COORD_BITS]  ? SIZE_MAX : src_width_reg;
    assign src_height = src_height_reg[COORD_BITS] ? SIZE_MAX : src_height_reg;
    assign dst_width  = dst_width_reg[COORD_BITS]  ? SIZE_MAX : dst_width_reg;
    assign dst_height = dst_height_reg[COORD_BITS] ? SIZE_MAX : dst_height_reg;

    assign src_left = src_left_reg;
    assign src_top  = src_top_reg;
    assign dst_left = dst_left_reg;
    assign dst_top  = dst_top_reg;

    assign src_col_end = CW'(src_left_reg) + src_width;
    assign src_row_end = CW'(src_top_reg)  + src_height;
    assign dst_col_end = CW'(dst_left_reg) + dst_width;
    assign dst_row_end = CW'(dst_top_reg)  + dst_height;

    assign ident = (src_width == dst_width) && (src_height == dst_height);

endmodule

`default_nettype wire

// ===== src/bsaw_walk.sv =====
`default_nettype none

module bsaw_walk #(
    parameter int COORD_BITS = bsaw_pkg::COORD_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire bsaw_pkg::walk_ctrl_t  ctrl,
    input  wire logic [COORD_BITS-1:0] src_left,
    input  wire logic [COORD_BITS-1:0] src_top,
    input  wire logic [COORD_BITS-1:0] dst_left,
    input  wire logic [COORD_BITS-1:0] dst_top,
    input  wire logic [COORD_BITS:0]   src_width,
    input  wire logic [COORD_BITS:0]   src_height,
    input  wire logic [COORD_BITS:0]   dst_width,
    input  wire logic [COORD_BITS:0]   dst_height,
    input  wire logic [COORD_BITS:0]   src_col_end,
    input  wire logic [COORD_BITS:0]   src_row_end,
    input  wire logic [COORD_BITS:0]   dst_col_end,
    input  wire logic [COORD_BITS:0]   dst_row_end,
    input  wire logic                  ident,
    output bsaw_pkg::walk_stat_t       stat,
    output logic      [COORD_BITS:0]   cur_src_col,
    output logic      [COORD_BITS:0]   cur_src_row,
    output logic      [COORD_BITS:0]   cur_dst_col,
    output logic      [COORD_BITS:0]   cur_dst_row
);
    import bsaw_pkg::*;

    localparam int CW = COORD_BITS + 1;
    localparam int LW = COORD_BITS + 3;   // error terms, two's complement

    logic [LW-1:0] col_level_reg, col_level_next;
    logic [LW-1:0] row_level_reg, row_level_next;
    logic [CW-1:0] src_col_reg, src_col_next;
    logic [CW-1:0] src_row_reg, src_row_next;
    logic [CW-1:0] dst_col_reg, dst_col_next;
    logic [CW-1:0] dst_row_reg, dst_row_next;
    logic          active_reg, active_next;
    logic          in_row_reg, in_row_next;

    logic          row_ok, col_ok, row_go, col_go;
    logic [LW-1:0] dw_dec, dh_dec, sw_neg, sh_neg;
    logic [LW-1:0] lvl_a, lvl_b, lvl_sum;

    assign row_ok = (dst_row_reg < dst_row_end) && (src_row_reg < src_row_end);
    assign col_ok = (dst_col_reg < dst_col_end) && (src_col_reg < src_col_end);
    assign row_go = ident || !row_level_reg[LW-1];
    assign col_go = ident || !col_level_reg[LW-1];

    // error term steps: up by size-1 on a source step, down by size-1 on a write
    assign dw_dec = LW'(dst_width)  - LW'(1);
    assign dh_dec = LW'(dst_height) - LW'(1);
    assign sw_neg = LW'(1) - LW'(src_width);
    assign sh_neg = LW'(1) - LW'(src_height);

    // the one error term adder, shared by both axes
    always_comb begin
        if (!in_row_reg) begin
            lvl_a = row_level_reg;
            lvl_b = dh_dec;
        end else if (!col_ok) begin
            lvl_a = row_level_reg;
            lvl_b = sh_neg;
        end else if (col_go) begin
            lvl_a = col_level_reg;
            lvl_b = sw_neg;
        end else begin
            lvl_a = col_level_reg;
            lvl_b = dw_dec;
        end
    end

    assign lvl_sum = lvl_a + lvl_b;

    always_comb begin
        col_level_next = col_level_reg;
        row_level_next = row_level_reg;
        src_col_next   = src_col_reg;
        src_row_next   = src_row_reg;
        dst_col_next   = dst_col_reg;
        dst_row_next   = dst_row_reg;
        active_next    = active_reg;
        in_row_next    = in_row_reg;
        stat.active    = active_reg;
        stat.emit      = 1'b0;
        stat.copy      = 1'b0;
        stat.done      = 1'b0;
        if (ctrl.load) begin
            row_level_next = LW'(dst_height >> 1);
            col_level_next = '0;
            src_col_next   = '0;
            dst_col_next   = '0;
            src_row_next   = CW'(src_top);
            dst_row_next   = CW'(dst_top);
            active_next    = 1'b1;
            in_row_next    = 1'b0;
        end else if (ctrl.step) begin
            if (!in_row_reg) begin
                if (!row_ok) begin
                    // no rows left
                    active_next = 1'b0;
                    stat.emit   = 1'b1;
                    stat.done   = 1'b1;
                end else if (row_go) begin
                    in_row_next    = 1'b1;
                    dst_col_next   = CW'(dst_left);
                    src_col_next   = CW'(src_left);
                    col_level_next = LW'(dst_width >> 1);
                end else begin
                    // source row skipped
                    row_level_next = lvl_sum;
                    src_row_next   = src_row_reg + CW'(1);
                end
            end else begin
                if (!col_ok) begin
                    // end of destination row
                    in_row_next = 1'b0;
                    if (ident) begin
                        src_row_next = src_row_reg + CW'(1);
                    end else begin
                        row_level_next = lvl_sum;
                    end
                    dst_row_next = dst_row_reg + CW'(1);
                end else if (col_go) begin
                    stat.emit = 1'b1;
                    stat.copy = 1'b1;
                    if (ident) begin
                        src_col_next = src_col_reg + CW'(1);
                    end else begin
                        col_level_next = lvl_sum;
                    end
                    dst_col_next = dst_col_reg + CW'(1);
                end else begin
                    // source column skipped
                    col_level_next = lvl_sum;
                    src_col_next   = src_col_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            in_row_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
            in_row_reg <= in_row_next;
        end
    end

    always_ff @(posedge aclk) begin
        col_level_reg <= col_level_next;
        row_level_reg <= row_level_next;
        src_col_reg   <= src_col_next;
        src_row_reg   <= src_row_next;
        dst_col_reg   <= dst_col_next;
        dst_row_reg   <= dst_row_next;
    end

    assign cur_src_col = src_col_reg;
    assign cur_src_row = src_row_reg;
    assign cur_dst_col = dst_col_reg;
    assign cur_dst_row = dst_row_reg;

endmodule

`default_nettype wire

// ===== src/bresenham_stretch_address_walker.sv =====
// address walker for a nearest-neighbour stretch copy
//
// configuration: write cfg_wr_data into the register named by cfg_addr while
// cfg_wr_en is high (source left/top/width/height, then destination
// left/top/width/height); sizes above the coordinate range saturate
// input channel (s_): one request per transfer; s_restart high starts a new
// walk, low asks for the next pixel copy of the running walk
// result channel (m_): exactly one result per request, either a copy
// (m_copy_valid with source and destination coordinates), an end of walk
// (m_walk_done), or an acknowledge of a restart (both flags low)
// restart requests and requests with no walk running have their result
// registered at the transfer; a copy request runs one walk iteration per
// skipped source column or row, per row start and per row end, and its
// result is registered by the iteration that emits the copy, so a copy
// needs fewer iterations when enlarging, more when shrinking
// one request is in flight at a time; s_ready is low while the walk iterates
// and while a result waits that the receiver is not taking this cycle
// reset clears the configuration registers and leaves no walk running; a
// stalled receiver simply holds the result register and the block waits

`default_nettype none

module bresenham_stretch_address_walker #(
    parameter int COORD_BITS = bsaw_pkg::COORD_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration
    input  wire logic                              cfg_wr_en,
    input  wire logic [bsaw_pkg::REG_IDX_BITS-1:0] cfg_addr,
    input  wire logic [COORD_BITS:0]               cfg_wr_data,
    // requests
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_restart,
    // results
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_copy_valid,
    output logic      [bsaw_pkg::OUT_BITS-1:0]     m_src_col,
    output logic      [bsaw_pkg::OUT_BITS-1:0]     m_src_row,
    output logic      [bsaw_pkg::OUT_BITS-1:0]     m_dst_col,
    output logic      [bsaw_pkg::OUT_BITS-1:0]     m_dst_row,
    output logic                                   m_walk_done
);
    import bsaw_pkg::*;

    localparam int CW = COORD_BITS + 1;

    // geometry, read live by the walk unit
    logic [COORD_BITS-1:0] src_left, src_top, dst_left, dst_top;
    logic [CW-1:0]         src_width, src_height, dst_width, dst_height;
    logic [CW-1:0]         src_col_end, src_row_end, dst_col_end, dst_row_end;
    logic                  ident;

    walk_ctrl_t  walk_ctrl;
    walk_stat_t  walk_stat;
    logic [CW-1:0] cur_src_col, cur_src_row, cur_dst_col, cur_dst_row;

    walk_state_t state_reg, state_next;

    logic                m_valid_reg, m_valid_next;
    logic                copy_reg, copy_next;
    logic                done_reg, done_next;
    logic [OUT_BITS-1:0] src_col_reg, src_col_next;
    logic [OUT_BITS-1:0] src_row_reg, src_row_next;
    logic [OUT_BITS-1:0] dst_col_reg, dst_col_next;
    logic [OUT_BITS-1:0] dst_row_reg, dst_row_next;

    logic in_xfer;
    logic out_free;

    bsaw_geom #(
        .COORD_BITS (COORD_BITS)
    ) u_geom (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .src_left    (src_left),
        .src_top     (src_top),
        .dst_left    (dst_left),
        .dst_top     (dst_top),
        .src_width   (src_width),
        .src_height  (src_height),
        .dst_width   (dst_width),
        .dst_height  (dst_height),
        .src_col_end (src_col_end),
        .src_row_end (src_row_end),
        .dst_col_end (dst_col_end),
        .dst_row_end (dst_row_end),
        .ident       (ident)
    );

    bsaw_walk #(
        .COORD_BITS (COORD_BITS)
    ) u_walk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (walk_ctrl),
        .src_left    (src_left),
        .src_top     (src_top),
        .dst_left    (dst_left),
        .dst_top     (dst_top),
        .src_width   (src_width),
        .src_height  (src_height),
        .dst_width   (dst_width),
        .dst_height  (dst_height),
        .src_col_end (src_col_end),
        .src_row_end (src_row_end),
        .dst_col_end (dst_col_end),
        .dst_row_end (dst_row_end),
        .ident       (ident),
        .stat        (walk_stat),
        .cur_src_col (cur_src_col),
        .cur_src_row (cur_src_row),
        .cur_dst_col (cur_dst_col),
        .cur_dst_row (cur_dst_row)
    );

    // result register is empty, or is handed over in this cycle
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign in_xfer  = s_valid && s_ready;

    // sequencer: next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer && !s_restart && walk_stat.active) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (walk_stat.emit) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer: walk unit control
    always_comb begin
        walk_ctrl.load = 1'b0;
        walk_ctrl.step = 1'b0;
        case (state_reg)
            ST_IDLE: walk_ctrl.load = in_xfer && s_restart;
            ST_WALK: walk_ctrl.step = 1'b1;
            default: ;
        endcase
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        copy_next    = copy_reg;
        done_next    = done_reg;
        src_col_next = src_col_reg;
        src_row_next = src_row_reg;
        dst_col_next = dst_col_reg;
        dst_row_next = dst_row_reg;
        if (in_xfer && (s_restart || !walk_stat.active)) begin
            // restart acknowledge, or a request with no walk running
            m_valid_next = 1'b1;
            copy_next    = 1'b0;
            done_next    = !s_restart;
            src_col_next = '0;
            src_row_next = '0;
            dst_col_next = '0;
            dst_row_next = '0;
        end else if ((state_reg == ST_WALK) && walk_stat.emit) begin
            m_valid_next = 1'b1;
            copy_next    = walk_stat.copy;
            done_next    = walk_stat.done;
            if (walk_stat.copy) begin
                src_col_next = OUT_BITS'(cur_src_col);
                src_row_next = OUT_BITS'(cur_src_row);
                dst_col_next = OUT_BITS'(cur_dst_col);
                dst_row_next = OUT_BITS'(cur_dst_row);
            end else begin
                src_col_next = '0;
                src_row_next = '0;
                dst_col_next = '0;
                dst_row_next = '0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        copy_reg    <= copy_next;
        done_reg    <= done_next;
        src_col_reg <= src_col_next;
        src_row_reg <= src_row_next;
        dst_col_reg <= dst_col_next;
        dst_row_reg <= dst_row_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_copy_valid = copy_reg;
    assign m_walk_done  = done_reg;
    assign m_src_col    = src_col_reg;
    assign m_src_row    = src_row_reg;
    assign m_dst_col    = dst_col_reg;
    assign m_dst_row    = dst_row_reg;

    // the result register is always empty while the walk iterates
    a_walk_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> !m_valid_reg)
        else $error("result pending while walk iterates");

    // iterating only makes sense with a walk running
    a_walk_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> walk_stat.active)
        else $error("walk iterating with no walk running");

    // a result never names a copy and the end of the walk at once
    a_copy_xor_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(copy_reg && done_reg))
        else $error("copy and walk done both set");

    // reporting the end of the walk stops it
    a_done_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_WALK) && walk_stat.emit && walk_stat.done)
        |=> (!walk_stat.active && (state_reg == ST_IDLE)))
        else $error("walk still running after end of walk");

endmodule

`default_nettype wire
